// ===== src/gcda_pkg.sv =====
// gcda_pkg: shared types, constants and elaboration-time table functions
// for the great-circle distance alarm; no dependencies
package gcda_pkg;

    // fixed-point word for cordic datapaths (q30 with headroom)
    localparam int W = 34;
    typedef logic signed [W-1:0] t_word;

    // angle input fraction bits
    localparam int ANG_FRAC = 16;

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint unsigned D2R_L = (PI_Q60 / 180 + (64'd1 << 23)) >> 24;
    localparam logic [30:0] D2R = D2R_L[30:0];
    localparam longint unsigned HALF_PI_L = (PI_Q60 + (64'd1 << 30)) >> 31;
    localparam t_word HALF_PI = t_word'(HALF_PI_L);
    localparam t_word ONE_Q30 = t_word'(64'd1 << 30);

    // angle constants in 2^-16 degree units
    localparam logic signed [26:0] FULL = 27'sd360 <<< ANG_FRAC;
    localparam logic signed [26:0] HALF = 27'sd180 <<< ANG_FRAC;
    localparam logic signed [26:0] QUARTER = 27'sd90 <<< ANG_FRAC;

    // rotation cell payload
    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        logic  flip;
    } t_rot;

    // square root cell payload
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
        t_word       c;
    } t_sqr;

    // vectoring cell payload
    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_vec;

    // unsigned quotient by shift and subtract, used for table building only
    function automatic longint unsigned udiv_c(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                q = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // integer square root, digit by digit
    function automatic longint unsigned isqrt_c(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan(2^-i) in q30 from a q60 series sum
    function automatic t_word atan_q30(input int i);
        longint unsigned a;
        longint unsigned term;
        int sh;
        a = 0;
        if (i == 0) begin
            a = PI_Q60 >> 2;
        end else begin
            for (int k = 0; k < 32; k++) begin
                sh = i * (2 * k + 1);
                if (sh <= 60) begin
                    term = udiv_c(64'd1 << (60 - sh), longint'(2 * k + 1));
                    if ((k & 1) == 1) a = a - term;
                    else a = a + term;
                end
            end
        end
        return t_word'((a + (64'd1 << 29)) >> 30);
    endfunction

    // reciprocal of the cordic gain in q30
    function automatic t_word gain_inv_q30(input int stages);
        longint unsigned p;
        longint unsigned sq;
        p = 64'd1 << 60;
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) p = p + (p >> (2 * i));
        end
        sq = isqrt_c(p);
        return t_word'(udiv_c((64'd1 << 60) + (sq >> 1), sq));
    endfunction

endpackage

// ===== src/gcda_rot_cell.sv =====
// gcda_rot_cell: one rotation-mode cordic micro-rotation, registered
// depends on gcda_pkg
module gcda_rot_cell #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  gcda_pkg::t_rot  i_d,
    output gcda_pkg::t_rot  o_d
);
    import gcda_pkg::*;

    localparam t_word ATAN = atan_q30(SHIFT);

    t_rot r_d;
    t_rot n_d;
    t_word w_xs;
    t_word w_ys;

    // rotate toward zero residual angle
    always_comb begin
        w_xs = i_d.x >>> SHIFT;
        w_ys = i_d.y >>> SHIFT;
        n_d = i_d;
        if (i_d.z >= 0) begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

// ===== src/gcda_vec_cell.sv =====
// gcda_vec_cell: one vectoring-mode cordic micro-rotation, registered
// depends on gcda_pkg
module gcda_vec_cell #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  gcda_pkg::t_vec  i_d,
    output gcda_pkg::t_vec  o_d
);
    import gcda_pkg::*;

    localparam t_word ATAN = atan_q30(SHIFT);

    t_vec r_d;
    t_vec n_d;
    t_word w_xs;
    t_word w_ys;

    // drive y toward zero, accumulate angle
    always_comb begin
        w_xs = i_d.x >>> SHIFT;
        w_ys = i_d.y >>> SHIFT;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + ATAN;
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

// ===== src/gcda_sqrt_cell.sv =====
// gcda_sqrt_cell: one digit step of a restoring integer square root
// depends on gcda_pkg
module gcda_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  gcda_pkg::t_sqr  i_d,
    output gcda_pkg::t_sqr  o_d
);
    import gcda_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (2 * STEP);

    t_sqr r_d;
    t_sqr n_d;
    logic [63:0] w_trial;

    // try to subtract the current trial value
    always_comb begin
        w_trial = i_d.r + BIT;
        n_d = i_d;
        if (i_d.n >= w_trial) begin
            n_d.n = i_d.n - w_trial;
            n_d.r = (i_d.r >> 1) + BIT;
        end else begin
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

// ===== src/great_circle_distance_alarm_core.sv =====
// great_circle_distance_alarm_core: fully pipelined, one position pair per cycle,
// busy is always low; o_done follows start through a valid shift register matched to the data path,
// which runs through the two cordic cell rows and the 32-step square root row
// each result shows on the ports for one cycle with o_done; the receiver cannot stall
// synchronous active-low reset clears the valid pipeline and restores both registers
module great_circle_distance_alarm_core #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_lat_a,
    input  logic signed [24:0] i_lon_a,
    input  logic signed [23:0] i_lat_b,
    input  logic signed [24:0] i_lon_b,
    output logic [20:0]        o_distance,
    output logic               o_danger,
    output logic               o_done
);
    import gcda_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam int SQ = 32;
    localparam int LAT = 2 * N + 43;
    localparam t_word GAIN_INV = gain_inv_q30(CORDIC_STAGES);
    localparam logic [25:0] DIST_MAX = 26'd2097151;

    typedef struct packed {
        logic [22:0] mag;
        logic        neg;
        logic        flip;
    } t_ang;

    // wrap to [-180,180) then fold to [-90,90]
    function automatic t_ang prep(input logic signed [26:0] t_in);
        logic signed [26:0] t;
        t_ang a;
        t = t_in;
        a.flip = 1'b0;
        if (t >= HALF) t = t - FULL;
        else if (t < -HALF) t = t + FULL;
        if (t > QUARTER) begin
            t = HALF - t;
            a.flip = 1'b1;
        end else if (t < -QUARTER) begin
            t = -HALF - t;
            a.flip = 1'b1;
        end
        a.neg = t[26];
        a.mag = t[26] ? 23'(-t) : 23'(t);
        return a;
    endfunction

    // q60 product rounded half up to q30
    function automatic t_word rnd30(input logic signed [67:0] p);
        logic signed [67:0] s;
        s = p + 68'sd536870912;
        return t_word'(s >>> 30);
    endfunction

    // config registers
    logic [19:0] r_radius;
    logic [20:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 20'd55000;
            r_limit  <= 21'd10000;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_limit <= pwdata[20:0];
            else r_radius <= pwdata[19:0];
        end
    end

    assign prdata = paddr[2] ? {11'd0, r_limit} : {12'd0, r_radius};
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // valid pipeline
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[LAT-2:0], start};
    end

    // input capture
    logic signed [23:0] r_la, r_lb;
    logic signed [24:0] r_loa, r_lob;
    always_ff @(posedge i_clk) begin
        r_la  <= i_lat_a;
        r_lb  <= i_lat_b;
        r_loa <= i_lon_a;
        r_lob <= i_lon_b;
    end

    // angle reduction
    t_ang r_aa, r_ab, r_ad;
    always_ff @(posedge i_clk) begin
        r_aa <= prep(27'(r_la));
        r_ab <= prep(27'(r_lb));
        r_ad <= prep(27'(r_loa) - 27'(r_lob));
    end

    // degrees to radians product
    logic [53:0] r_pa, r_pb, r_pd;
    logic [2:0]  r_na, r_nb;
    always_ff @(posedge i_clk) begin
        r_pa <= 54'(r_aa.mag) * 54'(D2R);
        r_pb <= 54'(r_ab.mag) * 54'(D2R);
        r_pd <= 54'(r_ad.mag) * 54'(D2R);
        r_na <= {r_ad.neg, r_ab.neg, r_aa.neg};
        r_nb <= {r_ad.flip, r_ab.flip, r_aa.flip};
    end

    // round to q30 and seed the rotation rows
    localparam logic [53:0] RAD_HALF = 54'd1 << (ANG_FRAC + 5);
    t_rot w_ra [0:N];
    t_rot w_rb [0:N];
    t_rot w_rd [0:N];
    t_rot r_sa, r_sb, r_sd;
    t_word w_za, w_zb, w_zd;

    always_comb begin
        w_za = t_word'((r_pa + RAD_HALF) >> (ANG_FRAC + 6));
        w_zb = t_word'((r_pb + RAD_HALF) >> (ANG_FRAC + 6));
        w_zd = t_word'((r_pd + RAD_HALF) >> (ANG_FRAC + 6));
    end

    always_ff @(posedge i_clk) begin
        r_sa <= '{x: GAIN_INV, y: '0, z: (r_na[0] ? -w_za : w_za), flip: r_nb[0]};
        r_sb <= '{x: GAIN_INV, y: '0, z: (r_na[1] ? -w_zb : w_zb), flip: r_nb[1]};
        r_sd <= '{x: GAIN_INV, y: '0, z: (r_na[2] ? -w_zd : w_zd), flip: r_nb[2]};
    end

    assign w_ra[0] = r_sa;
    assign w_rb[0] = r_sb;
    assign w_rd[0] = r_sd;

    // rotation cell rows for the three angles
    for (genvar i = 0; i < N; i++) begin : g_rot
        gcda_rot_cell #(.SHIFT(i)) u_ca (.i_clk(i_clk), .i_d(w_ra[i]), .o_d(w_ra[i+1]));
        gcda_rot_cell #(.SHIFT(i)) u_cb (.i_clk(i_clk), .i_d(w_rb[i]), .o_d(w_rb[i+1]));
        gcda_rot_cell #(.SHIFT(i)) u_cd (.i_clk(i_clk), .i_d(w_rd[i]), .o_d(w_rd[i+1]));
    end

    // law of cosines products
    t_word w_ca, w_cb, w_cd;
    t_word r_p1, r_q1, r_cd1, r_p2, r_q2, r_c;
    logic signed [W:0] w_sum;

    assign w_ca = w_ra[N].flip ? -w_ra[N].x : w_ra[N].x;
    assign w_cb = w_rb[N].flip ? -w_rb[N].x : w_rb[N].x;
    assign w_cd = w_rd[N].flip ? -w_rd[N].x : w_rd[N].x;
    assign w_sum = (W+1)'(r_p2) + (W+1)'(r_q2);

    always_ff @(posedge i_clk) begin
        r_p1  <= rnd30(68'(w_ca) * 68'(w_cb));
        r_q1  <= rnd30(68'(w_ra[N].y) * 68'(w_rb[N].y));
        r_cd1 <= w_cd;
        r_p2  <= rnd30(68'(r_p1) * 68'(r_cd1));
        r_q2  <= r_q1;
        if (w_sum > (W+1)'(ONE_Q30)) r_c <= ONE_Q30;
        else if (w_sum < -(W+1)'(ONE_Q30)) r_c <= -ONE_Q30;
        else r_c <= t_word'(w_sum);
    end

    // square root input: 2^60 - c*c
    t_sqr w_sq [0:SQ];
    t_sqr r_sq0;
    logic signed [67:0] w_cc;
    assign w_cc = 68'(r_c) * 68'(r_c);

    always_ff @(posedge i_clk) begin
        r_sq0.n <= (64'd1 << 60) - w_cc[63:0];
        r_sq0.r <= '0;
        r_sq0.c <= r_c;
    end

    assign w_sq[0] = r_sq0;

    // square root cell row, highest digit first
    for (genvar k = 0; k < SQ; k++) begin : g_sqr
        gcda_sqrt_cell #(.STEP(SQ - 1 - k)) u_cell (
            .i_clk(i_clk), .i_d(w_sq[k]), .o_d(w_sq[k+1])
        );
    end

    // seed the vectoring row, quadrant turn for negative c
    t_vec w_vc [0:N];
    t_vec r_v0;
    t_word w_s, w_c;
    assign w_s = t_word'(w_sq[SQ].r);
    assign w_c = w_sq[SQ].c;

    always_ff @(posedge i_clk) begin
        if (w_c < 0) r_v0 <= '{x: w_s, y: -w_c, z: HALF_PI};
        else r_v0 <= '{x: w_c, y: w_s, z: '0};
    end

    assign w_vc[0] = r_v0;

    // vectoring cell row
    for (genvar i = 0; i < N; i++) begin : g_vec
        gcda_vec_cell #(.SHIFT(i)) u_cell (.i_clk(i_clk), .i_d(w_vc[i]), .o_d(w_vc[i+1]));
    end

    // radius scaling
    logic [32:0] w_ang;
    logic [52:0] r_prod;
    assign w_ang = (w_vc[N].z < 0) ? 33'd0 : w_vc[N].z[32:0];

    always_ff @(posedge i_clk) begin
        r_prod <= 53'(r_radius) * 53'(w_ang);
    end

    // hundredths, rounding, saturation and alarm compare
    logic [59:0] w_scaled;
    logic [25:0] w_dist;
    logic [20:0] w_sat;
    logic [20:0] r_dist;
    logic        r_danger;

    assign w_scaled = 60'(r_prod) * 60'd100 + (60'd1 << 33);
    assign w_dist = w_scaled[59:34];
    assign w_sat = (w_dist > DIST_MAX) ? 21'h1FFFFF : w_dist[20:0];

    always_ff @(posedge i_clk) begin
        r_dist   <= w_sat;
        r_danger <= (w_sat < r_limit);
    end

    assign o_distance = r_dist;
    assign o_danger   = r_danger;
    assign o_done     = r_vld[LAT-1];
endmodule
